@@ rtl/palc_pkg.sv @@
// Package with the word types, command codes, alarm codes and register indexes of the alarm checker.
package palc_pkg;

  localparam logic [1:0] CMD_LEVEL = 2'd0;
  localparam logic [1:0] CMD_RATE  = 2'd1;
  localparam logic [1:0] CMD_ACK   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] CODE_NONE = 3'd0;
  localparam logic [2:0] CODE_HIHI = 3'd1;
  localparam logic [2:0] CODE_HI   = 3'd2;
  localparam logic [2:0] CODE_LO   = 3'd3;
  localparam logic [2:0] CODE_LOLO = 3'd4;
  localparam logic [2:0] CODE_RATE = 3'd5;

  localparam logic [7:0] REG_HIGH_HIGH = 8'd0;
  localparam logic [7:0] REG_HIGH      = 8'd1;
  localparam logic [7:0] REG_LOW       = 8'd2;
  localparam logic [7:0] REG_LOW_LOW   = 8'd3;
  localparam logic [7:0] REG_DEADBAND  = 8'd4;
  localparam logic [7:0] REG_ENABLE    = 8'd5;
  localparam logic [7:0] REG_RATE      = 8'd6;
  localparam logic [7:0] REG_MASK      = 8'd7;

  localparam logic [31:0] HIGH_HIGH_RESET = 32'd5898240;
  localparam logic [31:0] HIGH_RESET      = 32'd5242880;
  localparam logic [31:0] LOW_RESET       = 32'd1310720;
  localparam logic [31:0] LOW_LOW_RESET   = 32'd655360;
  localparam logic [63:0] DEADBAND_RESET  = 64'h0200_0100_0100_0200;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam int EN_HIHI = 0;
  localparam int EN_HI   = 1;
  localparam int EN_LO   = 2;
  localparam int EN_LOLO = 3;
  localparam int EN_RATE = 4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] sample_now;
    logic signed [31:0] sample_before;
    logic [15:0]        elapsed_ticks;
  } sample_t;

  typedef struct packed {
    logic [2:0]  alarm_code;
    logic        alarm_active;
    logic        ack_seen;
    logic [15:0] alarm_total;
  } result_t;

endpackage

@@ rtl/process_alarm_limit_checker.sv @@
// Top level of the process alarm limit checker with input register, check logic and result buffer.
// The block takes one sample word per clock while sample_ready is high and returns one result word
// for each, once the result side is ready. A word is held in an input register, then the
// limit chain, the rate check (one 32 by 16 multiply) and the state update run in a single
// combinational pass into the result register; a skid register behind it keeps the input side
// moving for one more word while a result waits. Level samples run HIHI, HI, LOLO, LO with
// deadband release of a latched alarm; rate samples compare the change against the rate limit
// times elapsed_ticks. Configuration registers must be written only while the block is idle.
module process_alarm_limit_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  palc_pkg::sample_t       sample_data,
  output logic                    result_valid,
  input  logic                    result_ready,
  output palc_pkg::result_t       result_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_index,
  input  logic [63:0]             cfg_data
);

  logic [31:0] high_high_limit;
  logic [31:0] high_limit;
  logic [31:0] low_limit;
  logic [31:0] low_low_limit;
  logic [63:0] deadband_pack;
  logic [4:0]  enable_mask;
  logic [31:0] rate_step;
  logic [1:0]  mask_flags;

  logic [2:0]  latched_alarm;
  logic        ack_flag;
  logic [15:0] alarm_counter;

  logic              s1_valid;
  palc_pkg::sample_t s1;
  logic              s1_go;
  logic              skid_valid;
  palc_pkg::result_t skid;
  logic              result_take;

  logic [2:0]        latched_next;
  logic              ack_next;
  logic [15:0]       counter_next;
  palc_pkg::result_t res;

  logic signed [33:0] v, hh, h, l, ll;
  logic signed [33:0] b_hh, b_h, b_l, b_ll;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [47:0]        allowed;
  logic [2:0]         lvl_code;
  logic [2:0]         lvl_latch;
  logic               done;

  assign cfg_ready    = 1'b1;
  assign sample_ready = !s1_valid || !skid_valid;
  assign s1_go        = s1_valid && !skid_valid;
  assign result_take  = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_high_limit <= palc_pkg::HIGH_HIGH_RESET;
      high_limit      <= palc_pkg::HIGH_RESET;
      low_limit       <= palc_pkg::LOW_RESET;
      low_low_limit   <= palc_pkg::LOW_LOW_RESET;
      deadband_pack   <= palc_pkg::DEADBAND_RESET;
      enable_mask     <= '0;
      rate_step       <= '0;
      mask_flags      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        palc_pkg::REG_HIGH_HIGH: high_high_limit <= cfg_data[31:0];
        palc_pkg::REG_HIGH:      high_limit      <= cfg_data[31:0];
        palc_pkg::REG_LOW:       low_limit       <= cfg_data[31:0];
        palc_pkg::REG_LOW_LOW:   low_low_limit   <= cfg_data[31:0];
        palc_pkg::REG_DEADBAND:  deadband_pack   <= cfg_data;
        palc_pkg::REG_ENABLE:    enable_mask     <= cfg_data[4:0];
        palc_pkg::REG_RATE:      rate_step       <= cfg_data[31:0];
        palc_pkg::REG_MASK:      mask_flags      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    v    = 34'(s1.sample_now);
    hh   = 34'($signed(high_high_limit));
    h    = 34'($signed(high_limit));
    l    = 34'($signed(low_limit));
    ll   = 34'($signed(low_low_limit));
    b_hh = $signed({10'b0, deadband_pack[15:0], 8'b0});
    b_h  = $signed({10'b0, deadband_pack[31:16], 8'b0});
    b_l  = $signed({10'b0, deadband_pack[47:32], 8'b0});
    b_ll = $signed({10'b0, deadband_pack[63:48], 8'b0});

    lvl_latch = latched_alarm;
    lvl_code  = palc_pkg::CODE_NONE;
    done      = 1'b0;

    if (enable_mask[palc_pkg::EN_HIHI] && v > hh) begin
      lvl_latch = palc_pkg::CODE_HIHI;
      lvl_code  = palc_pkg::CODE_HIHI;
      done      = 1'b1;
    end else if (lvl_latch == palc_pkg::CODE_HIHI) begin
      if (v > hh - b_hh) begin
        lvl_code = palc_pkg::CODE_HIHI;
        done     = 1'b1;
      end else begin
        lvl_latch = palc_pkg::CODE_NONE;
      end
    end

    if (!done) begin
      if (enable_mask[palc_pkg::EN_HI] && v > h) begin
        lvl_latch = palc_pkg::CODE_HI;
        lvl_code  = palc_pkg::CODE_HI;
        done      = 1'b1;
      end else if (lvl_latch == palc_pkg::CODE_HI) begin
        if (v > h - b_h) begin
          lvl_code = palc_pkg::CODE_HI;
          done     = 1'b1;
        end else begin
          lvl_latch = palc_pkg::CODE_NONE;
        end
      end
    end

    if (!done) begin
      if (enable_mask[palc_pkg::EN_LOLO] && v < ll) begin
        lvl_latch = palc_pkg::CODE_LOLO;
        lvl_code  = palc_pkg::CODE_LOLO;
        done      = 1'b1;
      end else if (lvl_latch == palc_pkg::CODE_LOLO) begin
        if (v < ll + b_ll) begin
          lvl_code = palc_pkg::CODE_LOLO;
          done     = 1'b1;
        end else begin
          lvl_latch = palc_pkg::CODE_NONE;
        end
      end
    end

    if (!done) begin
      if (enable_mask[palc_pkg::EN_LO] && v < l) begin
        lvl_latch = palc_pkg::CODE_LO;
        lvl_code  = palc_pkg::CODE_LO;
      end else if (lvl_latch == palc_pkg::CODE_LO) begin
        if (v < l + b_l) begin
          lvl_code = palc_pkg::CODE_LO;
        end else begin
          lvl_latch = palc_pkg::CODE_NONE;
        end
      end
    end
  end

  always_comb begin
    diff    = 33'(s1.sample_now) - 33'(s1.sample_before);
    mag     = diff[32] ? 33'(-diff) : 33'(diff);
    allowed = 48'(rate_step) * 48'(s1.elapsed_ticks);
  end

  always_comb begin
    latched_next = latched_alarm;
    ack_next     = ack_flag;
    counter_next = alarm_counter;
    res          = '0;
    unique case (s1.cmd)
      palc_pkg::CMD_LEVEL: begin
        latched_next = lvl_latch;
        res.alarm_code = lvl_code;
        if (lvl_code != palc_pkg::CODE_NONE && alarm_counter != palc_pkg::COUNT_MAX) begin
          counter_next = alarm_counter + 16'd1;
        end
      end
      palc_pkg::CMD_RATE: begin
        if (enable_mask[palc_pkg::EN_RATE] && s1.elapsed_ticks != 16'd0
            && 48'(mag) > allowed) begin
          latched_next   = palc_pkg::CODE_RATE;
          res.alarm_code = palc_pkg::CODE_RATE;
        end
      end
      palc_pkg::CMD_ACK: begin
        ack_next       = 1'b1;
        res.alarm_code = latched_alarm;
      end
      palc_pkg::CMD_CLEAR: begin
        counter_next   = '0;
        res.alarm_code = latched_alarm;
      end
      default: ;
    endcase
    res.alarm_active = (latched_next != palc_pkg::CODE_NONE) && (mask_flags == 2'd0);
    res.ack_seen     = ack_next;
    res.alarm_total  = counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s1 <= sample_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_alarm <= palc_pkg::CODE_NONE;
      ack_flag      <= 1'b0;
      alarm_counter <= '0;
    end else if (s1_go) begin
      latched_alarm <= latched_next;
      ack_flag      <= ack_next;
      alarm_counter <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (s1_go) begin
      if (!result_valid || result_take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result_take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      if (!result_valid || result_take) begin
        result_data <= res;
      end else begin
        skid <= res;
      end
    end else if (result_take && skid_valid) begin
      result_data <= skid;
    end
  end

  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("Skid register holds a word while the result register is empty.");

  a_stalled_input_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && skid_valid) |=> s1_valid)
    else $error("Input register word was lost while the result buffer was full.");

  a_ack_sticky: assert property (@(posedge clk) disable iff (rst)
    ack_flag |=> ack_flag)
    else $error("Acknowledge flag cleared without reset.");

  a_counter_saturates: assert property (@(posedge clk) disable iff (rst)
    (alarm_counter == palc_pkg::COUNT_MAX && !(s1_go && s1.cmd == palc_pkg::CMD_CLEAR))
    |=> alarm_counter == palc_pkg::COUNT_MAX)
    else $error("Alarm counter left saturation without a clear command.");

  a_latch_code_legal: assert property (@(posedge clk) disable iff (rst)
    latched_alarm != 3'd6 && latched_alarm != 3'd7)
    else $error("Latched alarm holds an undefined code.");

endmodule

@@ tb/process_alarm_limit_checker_tb.sv @@
// Self-checking testbench for the process alarm limit checker, with its own alarm predictor.
module process_alarm_limit_checker_tb;

  localparam int IDLE_PCT   = 6;
  localparam int LONG_STALL = 400;
  // TIMEOUT lies above LONG_STALL, the longest stall that a correct run makes.
  localparam int TIMEOUT    = 4000;
  localparam int SETTLE     = 4;
  localparam int Q16_ONE    = 65536;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_ready;
  palc_pkg::sample_t sample_data;
  logic              result_valid;
  logic              result_ready;
  palc_pkg::result_t result_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_index;
  logic [63:0]       cfg_data;

  logic signed [31:0] lim_hihi, lim_hi, lim_lo, lim_lolo;
  logic [63:0]        deadbands;
  logic [4:0]         enables;
  logic [31:0]        rate_per_tick;
  logic [1:0]         mask_bits;
  logic [2:0]         held_alarm;
  logic               ack_state;
  logic [15:0]        count_model;

  palc_pkg::result_t pending_verdicts[$];
  int      words_sent = 0;
  int      verdicts_seen = 0;
  int      alarm_verdicts = 0;
  int      reg_writes = 0;
  int      errors = 0;
  int      quiet_cycles = 0;
  int      stalls_asked = 0;
  int      stalls_served = 0;
  bit      steady = 1'b0;

  process_alarm_limit_checker dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [31:0] q16(input int whole);
    return whole * Q16_ONE;
  endfunction

  function automatic palc_pkg::sample_t make_word(input logic [1:0] cmd,
                                                  input logic [31:0] now,
                                                  input logic [31:0] prev,
                                                  input logic [15:0] ticks);
    palc_pkg::sample_t w;
    w.cmd           = cmd;
    w.sample_now    = now;
    w.sample_before = prev;
    w.elapsed_ticks = ticks;
    return w;
  endfunction

  function automatic longint band_q16(input int k);
    return longint'({40'd0, deadbands[16*k +: 16], 8'd0});
  endfunction

  function automatic void apply_reg(input logic [7:0] idx, input logic [63:0] val);
    case (idx)
      palc_pkg::REG_HIGH_HIGH: lim_hihi = val[31:0];
      palc_pkg::REG_HIGH:      lim_hi = val[31:0];
      palc_pkg::REG_LOW:       lim_lo = val[31:0];
      palc_pkg::REG_LOW_LOW:   lim_lolo = val[31:0];
      palc_pkg::REG_DEADBAND:  deadbands = val;
      palc_pkg::REG_ENABLE:    enables = val[4:0];
      palc_pkg::REG_RATE:      rate_per_tick = val[31:0];
      palc_pkg::REG_MASK:      mask_bits = val[1:0];
      default: ;
    endcase
  endfunction

  // A latched level alarm holds inside its deadband and is released once the sample leaves it.
  function automatic logic [2:0] level_verdict(input longint v);
    longint hh, h, l, ll;
    hh = lim_hihi;
    h  = lim_hi;
    l  = lim_lo;
    ll = lim_lolo;
    if (enables[palc_pkg::EN_HIHI] && v > hh) begin
      held_alarm = palc_pkg::CODE_HIHI;
      return palc_pkg::CODE_HIHI;
    end
    if (held_alarm == palc_pkg::CODE_HIHI) begin
      if (v > hh - band_q16(0)) return palc_pkg::CODE_HIHI;
      held_alarm = palc_pkg::CODE_NONE;
    end
    if (enables[palc_pkg::EN_HI] && v > h) begin
      held_alarm = palc_pkg::CODE_HI;
      return palc_pkg::CODE_HI;
    end
    if (held_alarm == palc_pkg::CODE_HI) begin
      if (v > h - band_q16(1)) return palc_pkg::CODE_HI;
      held_alarm = palc_pkg::CODE_NONE;
    end
    if (enables[palc_pkg::EN_LOLO] && v < ll) begin
      held_alarm = palc_pkg::CODE_LOLO;
      return palc_pkg::CODE_LOLO;
    end
    if (held_alarm == palc_pkg::CODE_LOLO) begin
      if (v < ll + band_q16(3)) return palc_pkg::CODE_LOLO;
      held_alarm = palc_pkg::CODE_NONE;
    end
    if (enables[palc_pkg::EN_LO] && v < l) begin
      held_alarm = palc_pkg::CODE_LO;
      return palc_pkg::CODE_LO;
    end
    if (held_alarm == palc_pkg::CODE_LO) begin
      if (v < l + band_q16(2)) return palc_pkg::CODE_LO;
      held_alarm = palc_pkg::CODE_NONE;
    end
    return palc_pkg::CODE_NONE;
  endfunction

  function automatic logic [2:0] rate_verdict(input palc_pkg::sample_t w);
    longint      diff;
    logic [63:0] mag;
    logic [63:0] allowed;
    diff    = longint'($signed(w.sample_now)) - longint'($signed(w.sample_before));
    mag     = (diff < 0) ? -diff : diff;
    allowed = {32'd0, rate_per_tick} * {48'd0, w.elapsed_ticks};
    if (!enables[palc_pkg::EN_RATE] || w.elapsed_ticks == 16'd0) return palc_pkg::CODE_NONE;
    if (mag > allowed) begin
      held_alarm = palc_pkg::CODE_RATE;
      return palc_pkg::CODE_RATE;
    end
    return palc_pkg::CODE_NONE;
  endfunction

  function automatic palc_pkg::result_t predict_verdict(input palc_pkg::sample_t w);
    palc_pkg::result_t r;
    logic [2:0]        code;
    case (w.cmd)
      palc_pkg::CMD_LEVEL: begin
        code = level_verdict($signed(w.sample_now));
        if (code != palc_pkg::CODE_NONE && count_model != palc_pkg::COUNT_MAX) count_model++;
      end
      palc_pkg::CMD_RATE: code = rate_verdict(w);
      palc_pkg::CMD_ACK: begin
        ack_state = 1'b1;
        code = held_alarm;
      end
      default: begin
        count_model = '0;
        code = held_alarm;
      end
    endcase
    r.alarm_code   = code;
    r.alarm_active = (held_alarm != palc_pkg::CODE_NONE) && (mask_bits == 2'b00);
    r.ack_seen     = ack_state;
    r.alarm_total  = count_model;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    palc_pkg::result_t want;
    logic              moved;
    if (rst) begin
      lim_hihi      = palc_pkg::HIGH_HIGH_RESET;
      lim_hi        = palc_pkg::HIGH_RESET;
      lim_lo        = palc_pkg::LOW_RESET;
      lim_lolo      = palc_pkg::LOW_LOW_RESET;
      deadbands     = palc_pkg::DEADBAND_RESET;
      enables       = '0;
      rate_per_tick = '0;
      mask_bits     = '0;
      held_alarm    = palc_pkg::CODE_NONE;
      ack_state     = 1'b0;
      count_model   = '0;
      quiet_cycles  = 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_writes++;
        moved = 1'b1;
      end
      if (sample_valid && sample_ready) begin
        pending_verdicts.push_back(predict_verdict(sample_data));
        moved = 1'b1;
      end
      if (result_valid && result_ready) begin
        moved = 1'b1;
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("Result word with no expectation waiting, alarm_code %0d",
                 result_data.alarm_code);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (want.alarm_code != palc_pkg::CODE_NONE) alarm_verdicts++;
          if (result_data.alarm_code !== want.alarm_code) begin
            $error("alarm_code: expected %0d, got %0d", want.alarm_code,
                   result_data.alarm_code);
            errors++;
          end
          if (result_data.alarm_active !== want.alarm_active) begin
            $error("alarm_active: expected %0d, got %0d", want.alarm_active,
                   result_data.alarm_active);
            errors++;
          end
          if (result_data.ack_seen !== want.ack_seen) begin
            $error("ack_seen: expected %0d, got %0d", want.ack_seen, result_data.ack_seen);
            errors++;
          end
          if (result_data.alarm_total !== want.alarm_total) begin
            $error("alarm_total: expected %0d, got %0d", want.alarm_total,
                   result_data.alarm_total);
            errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= TIMEOUT) begin
        $display("No word moved for %0d cycles.", TIMEOUT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : result_sink
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_served != stalls_asked) begin
        stalls_served++;
        result_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_word(input palc_pkg::sample_t w);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 25);
    end
    sample_valid <= 1'b1;
    sample_data  <= w;
    do @(posedge clk); while (!sample_ready);
    words_sent++;
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (verdicts_seen != words_sent);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] near_limit();
    logic signed [31:0] anchor;
    if ($urandom_range(0, 9) == 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       anchor = lim_hihi;
      1:       anchor = lim_hi;
      2:       anchor = lim_lo;
      default: anchor = lim_lolo;
    endcase
    return anchor + $urandom_range(0, 12 * Q16_ONE) - 6 * Q16_ONE;
  endfunction

  // The change is spread around the allowed limit so that both outcomes are common.
  function automatic palc_pkg::sample_t rate_word();
    logic [31:0] prev;
    logic [15:0] ticks;
    longint      span;
    prev  = near_limit();
    ticks = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    span  = longint'(rate_per_tick) * ticks;
    if (span > 1073741824) span = 1073741824;
    return make_word(palc_pkg::CMD_RATE,
                     prev + 32'($urandom_range(0, 32'(2 * span + 2))) - 32'(span + 1),
                     prev, ticks);
  endfunction

  task automatic test_reset_defaults();
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(100), '0, '0));
    send_word(make_word(palc_pkg::CMD_RATE, q16(50), q16(0), 16'd1));
  endtask

  task automatic test_limit_chain();
    write_reg(palc_pkg::REG_ENABLE, 64'h1F);
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(95), '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(89), '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(85), '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(80), '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(50), '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(5), '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(11), '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(15), '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(20), '0, '0));
  endtask

  task automatic test_rate_alarm();
    write_reg(palc_pkg::REG_RATE, 64'(Q16_ONE));
    send_word(make_word(palc_pkg::CMD_RATE, q16(1000), q16(0), 16'd0));
    send_word(make_word(palc_pkg::CMD_RATE, q16(10), q16(0), 16'd5));
    // A level sample inside all limits leaves the rate alarm latched.
    send_word(make_word(palc_pkg::CMD_LEVEL, q16(50), '0, '0));
    send_word(make_word(palc_pkg::CMD_RATE, q16(3), q16(0), 16'd3));
    send_word(make_word(palc_pkg::CMD_RATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
  endtask

  task automatic test_commands_and_masks();
    send_word(make_word(palc_pkg::CMD_ACK, $urandom, $urandom, 16'($urandom)));
    write_reg(palc_pkg::REG_MASK, 64'd1);
    send_word(make_word(palc_pkg::CMD_CLEAR, $urandom, $urandom, 16'($urandom)));
    write_reg(palc_pkg::REG_MASK, 64'd2);
    send_word(make_word(palc_pkg::CMD_ACK, $urandom, $urandom, 16'($urandom)));
    write_reg(palc_pkg::REG_MASK, 64'd0);
  endtask

  // Limits at the ends of the range with the widest deadbands must not wrap.
  task automatic test_extreme_limits();
    write_reg(palc_pkg::REG_DEADBAND, '1);
    write_reg(palc_pkg::REG_HIGH_HIGH, 64'h8000_0000);
    send_word(make_word(palc_pkg::CMD_LEVEL, 32'h7FFF_FFFF, '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, 32'h8000_0000, '0, '0));
    write_reg(palc_pkg::REG_HIGH_HIGH, 64'h7FFF_FFFF);
    write_reg(palc_pkg::REG_HIGH, 64'h7FFF_FFFF);
    write_reg(palc_pkg::REG_LOW, 64'h8000_0000);
    write_reg(palc_pkg::REG_LOW_LOW, 64'h8000_0000);
    send_word(make_word(palc_pkg::CMD_LEVEL, 32'h7FFF_FFFF, '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, 32'h8000_0000, '0, '0));
    write_reg(palc_pkg::REG_LOW_LOW, 64'h7FFF_FFFF);
    send_word(make_word(palc_pkg::CMD_LEVEL, 32'h8000_0000, '0, '0));
    send_word(make_word(palc_pkg::CMD_LEVEL, 32'h7FFF_FFFF, '0, '0));
    write_reg(8'd8, '1);
    write_reg(8'hFF, '1);
  endtask

  task automatic test_alarm_counting();
    int k;
    write_reg(palc_pkg::REG_ENABLE, 64'h01);
    write_reg(palc_pkg::REG_HIGH_HIGH, 64'h8000_0000);
    for (k = 0; k < 40; k++) begin
      send_word(make_word(palc_pkg::CMD_LEVEL, $urandom | 32'h1, $urandom, 16'($urandom)));
    end
    send_word(make_word(palc_pkg::CMD_CLEAR, $urandom, $urandom, 16'($urandom)));
  endtask

  task automatic test_random_phases();
    int                 phase;
    int                 k;
    int                 pick;
    int                 offset;
    logic signed [31:0] hihi, hi, lo, lolo;
    logic [63:0]        bands;
    for (phase = 0; phase < 4; phase++) begin
      if (phase == 3) begin
        hihi  = $urandom;
        hi    = $urandom;
        lo    = $urandom;
        lolo  = $urandom;
        bands = {$urandom, $urandom};
      end else begin
        offset = $urandom_range(0, 400);
        lolo   = (offset - 200) * Q16_ONE;
        lo     = lolo + $urandom_range(0, 10 * Q16_ONE);
        hi     = lo + $urandom_range(0, 40 * Q16_ONE);
        hihi   = hi + $urandom_range(0, 10 * Q16_ONE);
        bands  = {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                  16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024))};
      end
      write_reg(palc_pkg::REG_HIGH_HIGH, 64'(hihi));
      write_reg(palc_pkg::REG_HIGH, 64'(hi));
      write_reg(palc_pkg::REG_LOW, 64'(lo));
      write_reg(palc_pkg::REG_LOW_LOW, 64'(lolo));
      write_reg(palc_pkg::REG_DEADBAND, bands);
      write_reg(palc_pkg::REG_ENABLE, (phase == 0) ? 64'h1F : 64'($urandom_range(0, 31)));
      write_reg(palc_pkg::REG_RATE,
                (phase == 3) ? 64'($urandom) : 64'($urandom_range(0, 4 * Q16_ONE)));
      write_reg(palc_pkg::REG_MASK,
                ($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 3)) : 64'd0);
      steady = (phase == 1);
      if (phase == 2) stalls_asked++;
      for (k = 0; k < 500; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_word(make_word(palc_pkg::CMD_LEVEL, near_limit(), $urandom, 16'($urandom)));
        end else if (pick < 80) begin
          send_word(rate_word());
        end else if (pick < 87) begin
          send_word(make_word(palc_pkg::CMD_ACK, $urandom, $urandom, 16'($urandom)));
        end else if (pick < 92) begin
          send_word(make_word(palc_pkg::CMD_CLEAR, $urandom, $urandom, 16'($urandom)));
        end else begin
          send_word(make_word(2'($urandom), $urandom, $urandom, 16'($urandom)));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample_data  = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_limit_chain();
    test_rate_alarm();
    test_commands_and_masks();
    test_extreme_limits();
    test_alarm_counting();
    test_random_phases();
    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected result words never arrived", pending_verdicts.size());
      errors++;
    end
    $display("Checked %0d sample words, %0d with an alarm code, after %0d register writes.",
             verdicts_seen, alarm_verdicts, reg_writes);
    $display("Covered limit chain, rate checks, masks, extreme limits, clears and a long stall.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
